// ===== rtl/core/arrc_pkg.sv =====
`timescale 1ns / 1ps
package arrc_pkg;
	localparam int MAX_ORDER_DEF  = 32;
	localparam int COEF_WIDTH_DEF = 32;
	localparam int ORDER_W        = 6;
	localparam int ORDER_RESET    = 10;
	localparam int FRAC_BITS      = 24;
	localparam int NUM_W          = 66;
	localparam int DEN_W          = 34;
	localparam int ADDR_ORDER     = 0;
endpackage

// ===== rtl/core/ar_to_reflection_coefs_top.sv =====
`timescale 1ns / 1ps
// AR to reflection coefficient converter (step-down recursion), Q8.24.
// Input: pulse start with ar_coef while busy is low; one coefficient per
// transfer, first index first. After the order-th coefficient busy rises
// and the recursion runs from one coefficient memory and one mirror memory,
// both with registered synchronous reads.
// Each stage p copies its p coefficients to the mirror memory, then runs
// (p-1) divisions in the shared bit-serial divider, each skipped with a
// saturated or zero result when 1-k^2 is not positive. Start is ignored while busy.
// Output: order results, one per cycle, each marked by rc_valid for one
// cycle, index one first; last_rc flags the final one, unstable flags a
// vector in which some |k| reached one. The receiver cannot stall.
// Config: APB register order at address 0, to be written only while idle by
// the user; the block itself does not enforce this. A write drops any partial vector.
// Reset: order returns to 10, counters and flags clear; the memories hold
// no reset value: coefficient memory is filled by loading, mirror by copy.
module ar_to_reflection_coefs_top #(
	parameter int MAX_ORDER  = arrc_pkg::MAX_ORDER_DEF,
	parameter int COEF_WIDTH = arrc_pkg::COEF_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] ar_coef,
	output logic               rc_valid,
	output logic signed [31:0] rc_value,
	output logic               last_rc,
	output logic               unstable,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	logic [arrc_pkg::ORDER_W-1:0] order_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == 2'(arrc_pkg::ADDR_ORDER));
	assign prdata = (paddr == 2'(arrc_pkg::ADDR_ORDER)) ? 32'(order_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) order_q <= arrc_pkg::ORDER_W'(arrc_pkg::ORDER_RESET);
		else if (cfg_wr) order_q <= pwdata[arrc_pkg::ORDER_W-1:0];
	end

	arrc_core #(.MAX_ORDER(MAX_ORDER), .COEF_WIDTH(COEF_WIDTH)) u_core (
		.clk(clk), .arst_n(arst_n), .start(start), .ar_coef(ar_coef),
		.order(order_q), .cfg_wr(cfg_wr), .busy(busy), .rc_valid(rc_valid),
		.rc_value(rc_value), .last_rc(last_rc), .unstable(unstable)
	);
endmodule

// ===== rtl/core/arrc_div.sv =====
`timescale 1ns / 1ps
module arrc_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  go,
	input  logic signed [arrc_pkg::NUM_W-1:0]     num,
	input  logic        [arrc_pkg::DEN_W-1:0]     den,
	output logic                                  done,
	output logic signed [arrc_pkg::NUM_W-1:0]     quo
);
	localparam int NW = arrc_pkg::NUM_W;
	localparam int DW = arrc_pkg::DEN_W;
	logic [NW-1:0]   mag_q;
	logic [DW:0]     rem_q;
	logic [DW-1:0]   den_q;
	logic            neg_q;
	logic [6:0]      cnt_q;
	logic            run_q;
	logic [DW:0]     trial;
	logic [DW+1:0]   diff;

	assign trial = {rem_q[DW-1:0], mag_q[NW-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 7'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			mag_q <= num[NW-1] ? NW'(-num) : NW'(num);
			neg_q <= num[NW-1];
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			if (!diff[DW+1]) begin
				rem_q <= diff[DW:0];
				mag_q <= {mag_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				mag_q <= {mag_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? -$signed(mag_q) : $signed(mag_q);
endmodule

// ===== rtl/core/arrc_core.sv =====
`timescale 1ns / 1ps
module arrc_core #(
	parameter int MAX_ORDER  = arrc_pkg::MAX_ORDER_DEF,
	parameter int COEF_WIDTH = arrc_pkg::COEF_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [31:0]                ar_coef,
	input  logic [arrc_pkg::ORDER_W-1:0]      order,
	input  logic                              cfg_wr,
	output logic                              busy,
	output logic                              rc_valid,
	output logic signed [31:0]                rc_value,
	output logic                              last_rc,
	output logic                              unstable
);
	localparam int AW  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int CW  = AW + 1;
	localparam int SW  = (COEF_WIDTH > 32) ? 32 : COEF_WIDTH;
	localparam int NW  = arrc_pkg::NUM_W;
	localparam int DW  = arrc_pkg::DEN_W;
	localparam int FB  = arrc_pkg::FRAC_BITS;
	localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SW - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

	typedef enum logic [3:0] {
		S_IDLE, S_KRD, S_KWT, S_KMUL, S_CPRD, S_CPWR, S_JRD, S_JWT,
		S_MUL, S_DIV, S_DWT, S_LAST, S_ORD, S_OUT
	} state_t;
	state_t state_q;

	logic signed [31:0] coef_mem [MAX_ORDER];
	logic signed [31:0] mir_mem  [MAX_ORDER];
	logic signed [31:0] coef_rd, mir_a_rd, mir_b_rd;
	logic [AW-1:0]      coef_ra, mir_ra_a, mir_ra_b, coef_wa, mir_wa;
	logic               coef_we, mir_we;
	logic signed [31:0] coef_wd, mir_wd;

	logic [CW-1:0]      load_q, n_q, p_q, j_q, r_q;
	logic               unst_q;
	logic signed [31:0] k_q;
	logic signed [63:0] k2_q;
	logic signed [NW-1:0] num_q;
	logic [DW-1:0]      den_q;
	logic               den_bad_q;
	logic               div_go, div_done;
	logic signed [NW-1:0] quo;
	logic [CW-1:0]      eff_n;
	logic [CW-1:0]      load_next;
	logic signed [32:0] neg_x;
	logic signed [63:0] k2;

	assign eff_n = (order == '0) ? CW'(1) :
		({1'b0, order} > 7'(MAX_ORDER)) ? CW'(MAX_ORDER) : CW'(order);
	assign load_next = (load_q >= eff_n) ? CW'(1) : load_q + CW'(1);
	assign neg_x = -{ar_coef[31], ar_coef};
	assign k2 = (64'(k_q) * 64'(k_q)) >>> FB;

	always_ff @(posedge clk) begin
		if (coef_we) coef_mem[coef_wa] <= coef_wd;
		if (mir_we)  mir_mem[mir_wa]   <= mir_wd;
		coef_rd  <= coef_mem[coef_ra];
		mir_a_rd <= mir_mem[mir_ra_a];
		mir_b_rd <= mir_mem[mir_ra_b];
	end

	function automatic logic signed [31:0] sat(input logic signed [NW-1:0] v);
		if (v > NW'(SAT_HI)) return 32'(SAT_HI);
		if (v < NW'(SAT_LO)) return 32'(SAT_LO);
		return 32'(v);
	endfunction

	arrc_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .num(num_q), .den(den_q),
		.done(div_done), .quo(quo)
	);

	always_comb begin
		coef_we = 1'b0; coef_wa = AW'(load_q); coef_wd = sat(NW'(neg_x));
		mir_we = 1'b0; mir_wa = AW'(r_q); mir_wd = coef_rd;
		coef_ra = AW'(p_q - CW'(1));
		mir_ra_a = AW'(j_q);
		mir_ra_b = AW'(p_q - CW'(2) - j_q);
		div_go = 1'b0;
		case (state_q)
			S_IDLE: begin
				coef_we = start;
				if (load_q >= eff_n) coef_wa = '0;
			end
			S_CPRD: coef_ra = AW'(r_q);
			S_CPWR: begin
				coef_ra = AW'(r_q);
				mir_we = 1'b1;
				mir_wa = AW'(r_q - CW'(1));
			end
			S_MUL: div_go = !den_bad_q;
			S_DIV, S_DWT: begin
				coef_wa = AW'(j_q);
				if (den_bad_q) begin
					coef_wd = (num_q > 0) ? 32'(SAT_HI) : (num_q < 0) ? 32'(SAT_LO) : '0;
					coef_we = (state_q == S_DIV);
				end else begin
					coef_wd = sat(quo);
					coef_we = div_done;
				end
			end
			S_LAST, S_ORD: coef_ra = '0;
			S_OUT: coef_ra = AW'(r_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			load_q <= '0; n_q <= '0; p_q <= '0; j_q <= '0; r_q <= '0;
			unst_q <= 1'b0; rc_valid <= 1'b0; last_rc <= 1'b0;
			unstable <= 1'b0; rc_value <= '0;
		end else begin
			rc_valid <= (state_q == S_OUT) && (r_q != '0);
			if (cfg_wr) begin
				load_q <= '0;
				unst_q <= 1'b0;
			end else begin
				case (state_q)
					S_IDLE: if (start) begin
						if (load_q >= eff_n || load_q == '0) unst_q <= 1'b0;
						if (load_next == eff_n) begin
							n_q <= eff_n;
							p_q <= eff_n;
							load_q <= '0;
							state_q <= (eff_n == CW'(1)) ? S_LAST : S_KRD;
						end else
							load_q <= load_next;
					end
					S_KRD: state_q <= S_KWT;
					S_KWT: begin
						k_q <= coef_rd;
						state_q <= S_KMUL;
					end
					S_KMUL: begin
						k2_q <= k2;
						r_q <= '0;
						state_q <= S_CPRD;
					end
					S_CPRD: begin
						den_bad_q <= ((64'sd1 <<< FB) - k2_q) <= 0;
						den_q <= DW'((64'sd1 <<< FB) - k2_q);
						if ((64'sd1 <<< FB) - k2_q <= 0) unst_q <= 1'b1;
						r_q <= r_q + CW'(1);
						state_q <= S_CPWR;
					end
					S_CPWR: begin
						r_q <= r_q + CW'(1);
						if (r_q == p_q) begin
							j_q <= '0;
							state_q <= S_JRD;
						end
					end
					S_JRD: state_q <= S_JWT;
					S_JWT: begin
						num_q <= (NW'(mir_a_rd) <<< FB) - NW'(64'(k_q) * 64'(mir_b_rd));
						state_q <= S_MUL;
					end
					S_MUL: state_q <= S_DIV;
					S_DIV: if (den_bad_q) state_q <= S_DWT;
						else if (div_done) state_q <= S_DWT;
					S_DWT: begin
						if (j_q + CW'(2) == p_q) begin
							if (p_q == CW'(2)) state_q <= S_LAST;
							else begin
								p_q <= p_q - CW'(1);
								state_q <= S_KRD;
							end
						end else begin
							j_q <= j_q + CW'(1);
							state_q <= S_JRD;
						end
					end
					S_LAST: state_q <= S_ORD;
					S_ORD: begin
						if (coef_rd >= 32'sd16777216 || coef_rd <= -32'sd16777216) unst_q <= 1'b1;
						r_q <= '0;
						state_q <= S_OUT;
					end
					S_OUT: begin
						if (r_q != '0) begin
							rc_value <= coef_rd;
							last_rc <= (r_q == n_q);
							unstable <= unst_q;
						end
						r_q <= r_q + CW'(1);
						if (r_q == n_q) state_q <= S_IDLE;
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule
